[sv/ttcb_pkg.sv]
// ----------------------------------------------------------------------------
// ttcb_pkg: text console character buffer shared definitions
// Grid geometry, character codes, operation and state types, transfer structs.
// ----------------------------------------------------------------------------
package ttcb_pkg;

  // Grid store geometry
  localparam int MAX_ROWS = 32;
  localparam int MAX_COLS = 128;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;

  // Field widths of the cursor and configuration values
  localparam int CROW_W = 6;
  localparam int CCOL_W = 8;

  // Character codes
  localparam logic [7:0] CH_BELL      = 8'h07;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_FORMFEED  = 8'h0C;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  // Register reset values
  localparam logic [CROW_W-1:0] ROWS_RESET = 6'd32;
  localparam logic [CCOL_W-1:0] COLS_RESET = 8'd80;

  // Register indexes (APB word address)
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    OP_READ,
    OP_BELL,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_FORMFEED,
    OP_PRINT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_RD_DONE,
    ST_PUT,
    ST_CHAR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  typedef struct packed {
    logic [7:0]        cell_char;
    logic [CROW_W-1:0] cursor_at_row;
    logic [CCOL_W-1:0] cursor_at_col;
    logic              did_scroll;
  } result_t;

  // Queue entry as classified by the front end
  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } entry_t;

  // Front to back: head of the queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

  // Back to front: control and status
  typedef struct packed {
    logic pop;
    logic init_done;
  } back_ctrl_t;

endpackage

[sv/ttcb_front.sv]
// ----------------------------------------------------------------------------
// ttcb_front: command intake and classification
// Accepts items, decodes the operation and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ttcb_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  ttcb_pkg::item_t      item_i,
  input  ttcb_pkg::back_ctrl_t back_i,
  output ttcb_pkg::queue_head_t head_o
);

  ttcb_pkg::entry_t fifo_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;
  ttcb_pkg::entry_t new_entry;

  // Not ready while the queue is full or the grid is still being cleared
  assign busy = (count_q == 2'd2) || !back_i.init_done;
  assign push = start && !busy;

  // Classify the item
  always_comb begin
    new_entry.char_code = item_i.char_code;
    new_entry.read_row  = item_i.read_row;
    new_entry.read_col  = item_i.read_col;
    if (item_i.kind) begin
      new_entry.op = ttcb_pkg::OP_READ;
    end else begin
      case (item_i.char_code)
        ttcb_pkg::CH_BELL:      new_entry.op = ttcb_pkg::OP_BELL;
        ttcb_pkg::CH_NEWLINE:   new_entry.op = ttcb_pkg::OP_NEWLINE;
        ttcb_pkg::CH_BACKSPACE: new_entry.op = ttcb_pkg::OP_BACKSPACE;
        ttcb_pkg::CH_FORMFEED:  new_entry.op = ttcb_pkg::OP_FORMFEED;
        default:                new_entry.op = ttcb_pkg::OP_PRINT;
      endcase
    end
  end

  // Queue pointers
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (back_i.pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !back_i.pop) begin
      count_d = count_q + 2'd1;
    end else if (!push && back_i.pop) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= new_entry;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.entry = fifo_q[rd_ptr_q];

endmodule

[sv/ttcb_back.sv]
// ----------------------------------------------------------------------------
// ttcb_back: grid sequencer
// Owns the character grid and the cursor, runs scroll, clear and blank sweeps.
// ----------------------------------------------------------------------------
module ttcb_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ttcb_pkg::CROW_W-1:0]   rows_eff_i,
  input  logic [ttcb_pkg::CCOL_W-1:0]   cols_eff_i,
  input  ttcb_pkg::queue_head_t         head_i,
  output ttcb_pkg::back_ctrl_t          ctrl_o,
  output logic                          result_valid_o,
  output ttcb_pkg::result_t             result_o
);

  localparam int RW = ttcb_pkg::ROW_W;
  localparam int CW = ttcb_pkg::COL_W;
  localparam int AW = ttcb_pkg::ADDR_W;
  localparam int RN = ttcb_pkg::CROW_W;
  localparam int CN = ttcb_pkg::CCOL_W;

  ttcb_pkg::state_e state_q, state_d;
  ttcb_pkg::state_e ret_q, ret_d;
  ttcb_pkg::entry_t item_q, item_d;

  logic [RN-1:0] crow_q, crow_d;
  logic [CN-1:0] ccol_q, ccol_d;
  logic          scrolled_q, scrolled_d;
  logic          init_done_q, init_done_d;
  logic [RW-1:0] sr_q, sr_d;
  logic [CW-1:0] sc_q, sc_d;
  logic [RW-1:0] fr_q, fr_d;
  logic [CW-1:0] fc_q, fc_d;
  logic [RW-1:0] rlast_q, rlast_d;
  logic [CW-1:0] clast_q, clast_d;
  logic          res_valid_q, res_valid_d;
  ttcb_pkg::result_t res_q, res_d;
  logic          pop;

  // Grid memory
  logic [7:0]    mem [ttcb_pkg::MAX_ROWS * ttcb_pkg::MAX_COLS];
  logic [7:0]    rdata_q;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata;

  // Shared conditions
  logic [RN-1:0] crow_cl;
  logic [CN-1:0] ccol_cl;
  logic [RW-1:0] rows_m1;
  logic [RW-1:0] rows_m2;
  logic [CW-1:0] cols_m1;
  logic          one_row;
  logic          at_origin;
  logic          wrap_pend;
  logic          wrap_scroll;
  logic          nl_blank;
  logic          sc_last;
  logic          fc_last;
  logic          fr_last;
  logic          in_store;

  assign crow_cl     = (crow_q > rows_eff_i) ? rows_eff_i : crow_q;
  assign ccol_cl     = (ccol_q > cols_eff_i) ? cols_eff_i : ccol_q;
  assign rows_m1     = RW'(rows_eff_i - RN'(1));
  assign rows_m2     = RW'(rows_eff_i - RN'(2));
  assign cols_m1     = CW'(cols_eff_i - CN'(1));
  assign one_row     = (rows_eff_i == RN'(1));
  assign at_origin   = (crow_q == '0) && (ccol_q == '0);
  assign wrap_pend   = (ccol_q >= cols_eff_i);
  assign wrap_scroll = ((crow_q + RN'(1)) >= rows_eff_i);
  assign nl_blank    = (ccol_q < cols_eff_i);
  assign sc_last     = (sc_q == cols_m1);
  assign fc_last     = (fc_q == clast_q);
  assign fr_last     = (fr_q == rlast_q);
  assign in_store    = (int'(item_q.read_row) < ttcb_pkg::MAX_ROWS) &&
                       (int'(item_q.read_col) < ttcb_pkg::MAX_COLS);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ttcb_pkg::ST_IDLE: begin
        if (head_i.valid && init_done_q) begin
          state_d = (head_i.entry.op == ttcb_pkg::OP_READ) ?
                    ttcb_pkg::ST_READ : ttcb_pkg::ST_PUT;
        end
      end
      ttcb_pkg::ST_READ:    state_d = ttcb_pkg::ST_RD_DONE;
      ttcb_pkg::ST_RD_DONE: state_d = ttcb_pkg::ST_IDLE;
      ttcb_pkg::ST_PUT: begin
        if (crow_cl == rows_eff_i) begin
          state_d = one_row ? ttcb_pkg::ST_FILL : ttcb_pkg::ST_SCR_RD;
        end else begin
          state_d = ttcb_pkg::ST_CHAR;
        end
      end
      ttcb_pkg::ST_CHAR: begin
        case (item_q.op)
          ttcb_pkg::OP_NEWLINE: begin
            state_d = nl_blank ? ttcb_pkg::ST_FILL : ttcb_pkg::ST_DONE;
          end
          ttcb_pkg::OP_FORMFEED: state_d = ttcb_pkg::ST_FILL;
          ttcb_pkg::OP_PRINT: begin
            if (wrap_pend && wrap_scroll) begin
              state_d = one_row ? ttcb_pkg::ST_FILL : ttcb_pkg::ST_SCR_RD;
            end else begin
              state_d = ttcb_pkg::ST_DONE;
            end
          end
          default: state_d = ttcb_pkg::ST_DONE;
        endcase
      end
      ttcb_pkg::ST_SCR_RD: state_d = ttcb_pkg::ST_SCR_WR;
      ttcb_pkg::ST_SCR_WR: begin
        state_d = (sc_last && sr_q == rows_m2) ? ttcb_pkg::ST_FILL : ttcb_pkg::ST_SCR_RD;
      end
      ttcb_pkg::ST_FILL: begin
        if (fc_last && fr_last) begin
          state_d = ret_q;
        end
      end
      ttcb_pkg::ST_DONE: state_d = ttcb_pkg::ST_IDLE;
      default:           state_d = ttcb_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ret_d       = ret_q;
    item_d      = item_q;
    crow_d      = crow_q;
    ccol_d      = ccol_q;
    scrolled_d  = scrolled_q;
    init_done_d = init_done_q;
    sr_d        = sr_q;
    sc_d        = sc_q;
    fr_d        = fr_q;
    fc_d        = fc_q;
    rlast_d     = rlast_q;
    clast_d     = clast_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    pop         = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = {fr_q, fc_q};
    raddr       = {RW'(item_q.read_row), CW'(item_q.read_col)};
    wdata       = ttcb_pkg::CH_SPACE;

    case (state_q)
      ttcb_pkg::ST_IDLE: begin
        init_done_d = 1'b1;
        if (head_i.valid && init_done_q) begin
          pop        = 1'b1;
          item_d     = head_i.entry;
          scrolled_d = 1'b0;
        end
      end
      ttcb_pkg::ST_READ: begin
        re = 1'b1;
      end
      ttcb_pkg::ST_RD_DONE: begin
        res_valid_d       = 1'b1;
        res_d.cell_char   = in_store ? rdata_q : 8'h00;
        res_d.cursor_at_row = crow_q;
        res_d.cursor_at_col = ccol_q;
        res_d.did_scroll  = 1'b0;
      end
      ttcb_pkg::ST_PUT: begin
        crow_d = crow_cl;
        ccol_d = ccol_cl;
        // Pending scroll ahead of any character
        if (crow_cl == rows_eff_i) begin
          crow_d     = RN'(rows_m1);
          ccol_d     = '0;
          scrolled_d = 1'b1;
          sr_d       = '0;
          sc_d       = '0;
          fr_d       = rows_m1;
          fc_d       = '0;
          rlast_d    = rows_m1;
          clast_d    = cols_m1;
          ret_d      = ttcb_pkg::ST_CHAR;
        end
      end
      ttcb_pkg::ST_CHAR: begin
        case (item_q.op)
          ttcb_pkg::OP_NEWLINE: begin
            fr_d    = RW'(crow_q);
            fc_d    = CW'(ccol_q);
            rlast_d = RW'(crow_q);
            clast_d = cols_m1;
            ret_d   = ttcb_pkg::ST_DONE;
            crow_d  = crow_q + RN'(1);
            ccol_d  = '0;
          end
          ttcb_pkg::OP_BACKSPACE: begin
            if (!at_origin) begin
              we = 1'b1;
              if (ccol_q != '0) begin
                ccol_d = ccol_q - CN'(1);
                waddr  = {RW'(crow_q), CW'(ccol_q - CN'(1))};
              end else begin
                ccol_d = CN'(cols_m1);
                crow_d = crow_q - RN'(1);
                waddr  = {RW'(crow_q - RN'(1)), cols_m1};
              end
            end
          end
          ttcb_pkg::OP_FORMFEED: begin
            fr_d    = '0;
            fc_d    = '0;
            rlast_d = rows_m1;
            clast_d = cols_m1;
            ret_d   = ttcb_pkg::ST_DONE;
            crow_d  = '0;
            ccol_d  = '0;
          end
          ttcb_pkg::OP_PRINT: begin
            if (wrap_pend && wrap_scroll) begin
              // Wrap off the last row: scroll, then store on return
              crow_d     = RN'(rows_m1);
              ccol_d     = '0;
              scrolled_d = 1'b1;
              sr_d       = '0;
              sc_d       = '0;
              fr_d       = rows_m1;
              fc_d       = '0;
              rlast_d    = rows_m1;
              clast_d    = cols_m1;
              ret_d      = ttcb_pkg::ST_CHAR;
            end else if (wrap_pend) begin
              we     = 1'b1;
              wdata  = item_q.char_code;
              waddr  = {RW'(crow_q + RN'(1)), CW'(0)};
              crow_d = crow_q + RN'(1);
              ccol_d = CN'(1);
            end else begin
              we     = 1'b1;
              wdata  = item_q.char_code;
              waddr  = {RW'(crow_q), CW'(ccol_q)};
              ccol_d = ccol_q + CN'(1);
            end
          end
          default: begin
          end
        endcase
      end
      ttcb_pkg::ST_SCR_RD: begin
        re    = 1'b1;
        raddr = {sr_q + RW'(1), sc_q};
      end
      ttcb_pkg::ST_SCR_WR: begin
        we    = 1'b1;
        wdata = rdata_q;
        waddr = {sr_q, sc_q};
        if (sc_last) begin
          sc_d = '0;
          sr_d = sr_q + RW'(1);
        end else begin
          sc_d = sc_q + CW'(1);
        end
      end
      ttcb_pkg::ST_FILL: begin
        we = 1'b1;
        if (fc_last) begin
          if (!fr_last) begin
            fr_d = fr_q + RW'(1);
            fc_d = '0;
          end
        end else begin
          fc_d = fc_q + CW'(1);
        end
      end
      ttcb_pkg::ST_DONE: begin
        res_valid_d         = 1'b1;
        res_d.cell_char     = 8'h00;
        res_d.cursor_at_row = crow_q;
        res_d.cursor_at_col = ccol_q;
        res_d.did_scroll    = scrolled_q;
      end
      default: begin
      end
    endcase
  end

  // Control registers; reset starts the clearing sweep over the whole store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ttcb_pkg::ST_FILL;
      ret_q       <= ttcb_pkg::ST_IDLE;
      crow_q      <= '0;
      ccol_q      <= '0;
      scrolled_q  <= 1'b0;
      init_done_q <= 1'b0;
      sr_q        <= '0;
      sc_q        <= '0;
      fr_q        <= '0;
      fc_q        <= '0;
      rlast_q     <= RW'(ttcb_pkg::MAX_ROWS - 1);
      clast_q     <= CW'(ttcb_pkg::MAX_COLS - 1);
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      crow_q      <= crow_d;
      ccol_q      <= ccol_d;
      scrolled_q  <= scrolled_d;
      init_done_q <= init_done_d;
      sr_q        <= sr_d;
      sc_q        <= sc_d;
      fr_q        <= fr_d;
      fc_q        <= fc_d;
      rlast_q     <= rlast_d;
      clast_q     <= clast_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
  end

  // Grid memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign ctrl_o.pop       = pop;
  assign ctrl_o.init_done = init_done_q;
  assign result_valid_o   = res_valid_q;
  assign result_o         = res_q;

endmodule

[sv/text_console_char_buffer.sv]
// ----------------------------------------------------------------------------
// text_console_char_buffer: character grid and cursor of a text console
//
// Items enter on start/item_i and are taken at an edge where start is high
// and busy is low. Each item gives one result on result_o, marked by
// result_valid_o for exactly one cycle; the receiver cannot stall it.
// A two-entry queue sits between intake and the grid sequencer, so busy
// rises only when the queue is full or the grid is being cleared.
// A read returns the cell through the registered read port. A put first
// runs any pending scroll, then acts on the character: newline blanks the
// rest of the row, form feed the whole grid, and a printable that wraps
// off the last row scrolls first. The sequencer takes a new item only when
// it is through with the last; its sweeps go one cell at a time.
// Reset clears the cursor and starts a clearing pass over all 4096 cells
// of the store; busy stays high through it. Registers rows_in_use (0x0)
// and cols_in_use (0x4) are written over the APB port; the user must write
// them only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module text_console_char_buffer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ttcb_pkg::item_t              item_i,
  output logic                         result_valid_o,
  output ttcb_pkg::result_t            result_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [ttcb_pkg::CROW_W-1:0] rows_q;
  logic [ttcb_pkg::CCOL_W-1:0] cols_q;
  logic [ttcb_pkg::CROW_W-1:0] rows_eff;
  logic [ttcb_pkg::CCOL_W-1:0] cols_eff;
  logic                        wr_en;
  ttcb_pkg::queue_head_t       head;
  ttcb_pkg::back_ctrl_t        back_ctrl;

  // Configuration registers
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ttcb_pkg::ROWS_RESET;
      cols_q <= ttcb_pkg::COLS_RESET;
    end else if (wr_en) begin
      if (paddr[2] == ttcb_pkg::REG_ROWS) begin
        rows_q <= pwdata[ttcb_pkg::CROW_W-1:0];
      end else begin
        cols_q <= pwdata[ttcb_pkg::CCOL_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == ttcb_pkg::REG_COLS) ? 32'(cols_q) : 32'(rows_q);

  // Zero acts as one, oversize acts as the store limit
  assign rows_eff = (rows_q == '0) ? ttcb_pkg::CROW_W'(1) :
                    (int'(rows_q) > ttcb_pkg::MAX_ROWS) ?
                    ttcb_pkg::CROW_W'(ttcb_pkg::MAX_ROWS) : rows_q;
  assign cols_eff = (cols_q == '0) ? ttcb_pkg::CCOL_W'(1) :
                    (int'(cols_q) > ttcb_pkg::MAX_COLS) ?
                    ttcb_pkg::CCOL_W'(ttcb_pkg::MAX_COLS) : cols_q;

  ttcb_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .item_i (item_i),
    .back_i (back_ctrl),
    .head_o (head)
  );

  ttcb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rows_eff_i     (rows_eff),
    .cols_eff_i     (cols_eff),
    .head_i         (head),
    .ctrl_o         (back_ctrl),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

[sv/ttcb_checker.sv]
// ----------------------------------------------------------------------------
// ttcb_checker: port-level checks for the text console character buffer
// Watches results and the configuration port over time.
// ----------------------------------------------------------------------------
module ttcb_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              result_valid_o,
  input ttcb_pkg::result_t result_o,
  input logic              pready
);

  // Result strobes never come back to back
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  // A scrolled item is a put, which reports no cell
  a_scroll_put: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.did_scroll) |-> (result_o.cell_char == 8'h00))
    else $error("scroll reported with a cell value");

  // Cursor never goes past the pending position
  a_cursor_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (int'(result_o.cursor_at_row) <= ttcb_pkg::MAX_ROWS))
    else $error("cursor row out of range");

  a_cursor_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (int'(result_o.cursor_at_col) <= ttcb_pkg::MAX_COLS))
    else $error("cursor column out of range");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("configuration port not ready");

endmodule

bind text_console_char_buffer ttcb_checker u_ttcb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .result_valid_o (result_valid_o),
  .result_o       (result_o),
  .pready         (pready)
);

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the text console character buffer
// Puts characters and reads cells, predicts grid, cursor and scroll flag in
// a local copy of the console, and checks every result strobe against it.
// ----------------------------------------------------------------------------
module tb;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  ttcb_pkg::item_t   item_i = '0;
  logic              result_valid_o;
  ttcb_pkg::result_t result_o;
  logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  text_console_char_buffer uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Local console copy
  logic [7:0]        grid_cells [ttcb_pkg::MAX_ROWS][ttcb_pkg::MAX_COLS];
  int                cur_row, cur_col;
  int                rows_reg, cols_reg;
  ttcb_pkg::result_t pending_results[$];
  int                n_errors, n_results, n_scrolls, n_items;
  int                sender_idle_pct;
  longint            cycle_count;
  int                rows_set[6] = '{2, 1, 0, 40, 5, 32};
  int                cols_set[6] = '{3, 128, 0, 255, 7, 80};

  function automatic int eff_rows();
    if (rows_reg == 0) return 1;
    if (rows_reg > ttcb_pkg::MAX_ROWS) return ttcb_pkg::MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic int eff_cols();
    if (cols_reg == 0) return 1;
    if (cols_reg > ttcb_pkg::MAX_COLS) return ttcb_pkg::MAX_COLS;
    return cols_reg;
  endfunction

  function automatic void scroll_grid(int nr, int nc);
    for (int r = 0; r + 1 < nr; r++)
      for (int c = 0; c < nc; c++) grid_cells[r][c] = grid_cells[r+1][c];
    for (int c = 0; c < nc; c++) grid_cells[nr-1][c] = ttcb_pkg::CH_SPACE;
  endfunction

  // Apply one item to the console copy and give its result
  function automatic ttcb_pkg::result_t console_step(ttcb_pkg::item_t it);
    ttcb_pkg::result_t res;
    int nr, nc;
    nr = eff_rows();
    nc = eff_cols();
    res = '0;
    if (it.kind) begin
      res.cell_char = grid_cells[it.read_row][it.read_col];
    end else begin
      if (cur_row > nr) cur_row = nr;
      if (cur_col > nc) cur_col = nc;
      if (cur_row == nr) begin
        scroll_grid(nr, nc);
        res.did_scroll = 1'b1;
        cur_row = nr - 1;
        cur_col = 0;
      end
      case (it.char_code)
        ttcb_pkg::CH_BELL: ;
        ttcb_pkg::CH_NEWLINE: begin
          for (int c = cur_col; c < nc; c++) grid_cells[cur_row][c] = ttcb_pkg::CH_SPACE;
          cur_col = 0;
          cur_row++;
        end
        ttcb_pkg::CH_BACKSPACE: begin
          if (cur_row != 0 || cur_col != 0) begin
            if (cur_col != 0) cur_col--;
            else begin
              cur_col = nc - 1;
              cur_row--;
            end
            grid_cells[cur_row][cur_col] = ttcb_pkg::CH_SPACE;
          end
        end
        ttcb_pkg::CH_FORMFEED: begin
          for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++) grid_cells[r][c] = ttcb_pkg::CH_SPACE;
          cur_row = 0;
          cur_col = 0;
        end
        default: begin
          if (cur_col >= nc) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= nr) begin
              scroll_grid(nr, nc);
              res.did_scroll = 1'b1;
              cur_row = nr - 1;
            end
          end
          if (cur_col < ttcb_pkg::MAX_COLS) grid_cells[cur_row][cur_col] = it.char_code;
          cur_col++;
        end
      endcase
    end
    res.cursor_at_row = cur_row[ttcb_pkg::CROW_W-1:0];
    res.cursor_at_col = cur_col[ttcb_pkg::CCOL_W-1:0];
    return res;
  endfunction

  // Result checker: compares each strobe with the oldest expectation
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_o);
        n_errors++;
      end else begin
        ttcb_pkg::result_t exp_r;
        exp_r = pending_results.pop_front();
        n_results++;
        if (result_o.did_scroll) n_scrolls++;
        if (result_o.cell_char !== exp_r.cell_char ||
            result_o.cursor_at_row !== exp_r.cursor_at_row ||
            result_o.cursor_at_col !== exp_r.cursor_at_col ||
            result_o.did_scroll !== exp_r.did_scroll) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, result_o);
          n_errors++;
        end
      end
    end
  end

  // Timeout
  initial begin
    cycle_count = 0;
    wait (cycle_count > 64'd40000000);
    $display("text_console_char_buffer verification failed");
    $finish;
  end

  task automatic reg_write(input logic idx, input int value);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == ttcb_pkg::REG_ROWS) rows_reg = value & 'h3F;
    else cols_reg = value & 'hFF;
  endtask

  // Offer one item and hold it until taken; prediction at the transfer
  task automatic send_item(input ttcb_pkg::item_t it, input bit use_exp,
                           input ttcb_pkg::result_t exp_r);
    ttcb_pkg::result_t pred;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pred = console_step(it);
    if (use_exp && pred != exp_r) begin
      $display("%0t: directed row disagrees expected %p predicted %p", $time, exp_r, pred);
      n_errors++;
    end
    pending_results.push_back(pred);
    n_items++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < 2000000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (9000) @(posedge clk_i);
  endtask

  function automatic ttcb_pkg::item_t mk(bit k, int ch, int rr, int rc);
    ttcb_pkg::item_t it;
    it.kind = k;
    it.char_code = 8'(ch);
    it.read_row = 5'(rr);
    it.read_col = 7'(rc);
    return it;
  endfunction

  function automatic ttcb_pkg::result_t mkr(int cc, int r, int c, bit s);
    ttcb_pkg::result_t res;
    res.cell_char = 8'(cc);
    res.cursor_at_row = ttcb_pkg::CROW_W'(r);
    res.cursor_at_col = ttcb_pkg::CCOL_W'(c);
    res.did_scroll = s;
    return res;
  endfunction

  // Random item: mostly printable text with control codes and reads
  function automatic ttcb_pkg::item_t rand_item();
    int sel, ch;
    sel = $urandom_range(99);
    if (sel < 20) return mk(1, $urandom_range(255), $urandom_range(31), $urandom_range(127));
    if (sel < 30) ch = ttcb_pkg::CH_NEWLINE;
    else if (sel < 36) ch = ttcb_pkg::CH_BACKSPACE;
    else if (sel < 39) ch = ttcb_pkg::CH_BELL;
    else if (sel < 40) ch = ttcb_pkg::CH_FORMFEED;
    else if (sel < 50) ch = $urandom_range(255);
    else ch = $urandom_range(126, 33);
    return mk(0, ch, $urandom_range(31), $urandom_range(127));
  endfunction

  typedef struct {
    ttcb_pkg::item_t   it;
    bit                use_exp;
    ttcb_pkg::result_t exp_r;
  } stim_row_t;

  initial begin
    stim_row_t dir_rows[$];

    for (int r = 0; r < ttcb_pkg::MAX_ROWS; r++)
      for (int c = 0; c < ttcb_pkg::MAX_COLS; c++) grid_cells[r][c] = ttcb_pkg::CH_SPACE;
    cur_row = 0;
    cur_col = 0;
    rows_reg = ttcb_pkg::ROWS_RESET;
    cols_reg = ttcb_pkg::COLS_RESET;
    n_errors = 0;
    sender_idle_pct = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows at reset geometry
    dir_rows = '{
      '{mk(1, 0, 0, 0),                     1, mkr(ttcb_pkg::CH_SPACE, 0, 0, 0)},
      '{mk(1, 0, 31, 127),                  1, mkr(ttcb_pkg::CH_SPACE, 0, 0, 0)},
      '{mk(0, ttcb_pkg::CH_BACKSPACE, 0, 0), 1, mkr(0, 0, 0, 0)},
      '{mk(0, ttcb_pkg::CH_BELL, 0, 0),     1, mkr(0, 0, 0, 0)},
      '{mk(0, 'h41, 0, 0),                  1, mkr(0, 0, 1, 0)},
      '{mk(1, 0, 0, 0),                     1, mkr('h41, 0, 1, 0)},
      '{mk(0, 'hFF, 0, 0),                  1, mkr(0, 0, 2, 0)},
      '{mk(0, 'h00, 0, 0),                  1, mkr(0, 0, 3, 0)},
      '{mk(0, ttcb_pkg::CH_BACKSPACE, 0, 0), 1, mkr(0, 0, 2, 0)},
      '{mk(0, ttcb_pkg::CH_NEWLINE, 0, 0),  1, mkr(0, 1, 0, 0)},
      '{mk(0, ttcb_pkg::CH_BACKSPACE, 0, 0), 1, mkr(0, 0, 79, 0)},
      '{mk(1, 0, 0, 1),                     1, mkr('hFF, 0, 79, 0)},
      '{mk(0, ttcb_pkg::CH_FORMFEED, 0, 0), 1, mkr(0, 0, 0, 0)},
      '{mk(1, 0, 0, 0),                     1, mkr(ttcb_pkg::CH_SPACE, 0, 0, 0)}
    };
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].use_exp, dir_rows[i].exp_r);
    drain();

    // Small grid: wrap, scroll on wrap, pending scroll, bell on pending scroll
    reg_write(ttcb_pkg::REG_ROWS, 2);
    reg_write(ttcb_pkg::REG_COLS, 3);
    for (int i = 0; i < 7; i++) send_item(mk(0, 'h61 + i, 0, 0), 0, '0);
    send_item(mk(0, ttcb_pkg::CH_NEWLINE, 0, 0), 0, '0);
    send_item(mk(0, ttcb_pkg::CH_BELL, 0, 0), 1, mkr(0, 1, 0, 1));
    send_item(mk(0, ttcb_pkg::CH_NEWLINE, 0, 0), 0, '0);
    send_item(mk(0, ttcb_pkg::CH_NEWLINE, 0, 0), 0, '0);
    send_item(mk(1, 0, 0, 1), 0, '0);
    send_item(mk(1, 0, 5, 100), 0, '0);
    drain();
    // Grow the grid, then shrink it below the cursor: clamping
    reg_write(ttcb_pkg::REG_ROWS, 4);
    send_item(mk(0, ttcb_pkg::CH_NEWLINE, 0, 0), 0, '0);
    send_item(mk(0, ttcb_pkg::CH_NEWLINE, 0, 0), 0, '0);
    send_item(mk(0, 'h7A, 0, 0), 0, '0);
    drain();
    reg_write(ttcb_pkg::REG_ROWS, 1);
    reg_write(ttcb_pkg::REG_COLS, 1);
    send_item(mk(0, 'h5A, 0, 0), 0, '0);
    send_item(mk(0, 'h5B, 0, 0), 0, '0);
    drain();

    // Random phases over several geometries and idle rates
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(ttcb_pkg::REG_ROWS, rows_set[ph]);
      reg_write(ttcb_pkg::REG_COLS, cols_set[ph]);
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 58;
        2: sender_idle_pct = 23;
        default: sender_idle_pct = 58;
      endcase
      for (int i = 0; i < 75; i++) send_item(rand_item(), 0, '0);
      drain();
    end

    $display("Ran %0d items, %0d results checked, %0d scrolls, %0d errors.",
             n_items, n_results, n_scrolls, n_errors);
    if (n_errors == 0 && pending_results.size() == 0)
      $display("text_console_char_buffer verification clean");
    else
      $display("text_console_char_buffer verification failed");
    $finish;
  end

endmodule

[files.f]
sv/ttcb_pkg.sv
sv/ttcb_front.sv
sv/ttcb_back.sv
sv/text_console_char_buffer.sv
sv/ttcb_checker.sv
dv/tb.sv
